/* design/b64e_pkg.sv */
// Shared types, constants and the Base64 alphabet function for the stream encoder.
// No dependencies; imported by the encoder top level, front end, queue and back end.
package b64e_pkg;

  localparam int unsigned QDepthDef = 2;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  // Position inside the current 3-byte group.
  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_e;

  // Characters produced by one input byte, emitted from index 0 up to last_idx.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            msg_last;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = PlusChar;
    end else begin
      c = SlashChar;
    end
    return c;
  endfunction

endpackage

/* design/b64e_if.sv */
// Valid/ready stream interfaces for raw bytes in and Base64 characters out.
// Depends on nothing; used by the encoder top level.
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

/* design/base64_stream_encoder_unit.sv */
// Base64 stream encoder (standard alphabet, '=' padded). Each input request
// carries one byte and a last-byte flag; each output request carries one ASCII
// character, with last_char set on the final '=' or character of the message.
// A byte yields one or two characters, plus a flush character and padding on
// a last byte that ends a partial group (up to four). The front end takes a
// byte every cycle while the job queue (QueueDepth entries) has room; the output
// side sends one character per cycle while out_o.ready is high, so the sustained
// input rate is set by the output port, which sends four characters for every
// three bytes. A byte passes through the queue, the job register and the output
// register before its first character is offered. No clearing pass after reset.
module base64_stream_encoder_unit
  import b64e_pkg::*;
#(
  parameter int unsigned QueueDepth = QDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64e_in_if.sink     in_i,
  b64e_out_if.source  out_o
);

  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .data_byte_i  (in_i.data_byte),
    .last_byte_i  (in_i.last_byte),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .last_char_o (out_o.last_char)
  );

endmodule

/* design/b64e_front.sv */
// Front end: takes one byte per request, tracks group phase and leftover bits,
// and builds the list of characters that byte produces. Uses b64e_pkg.
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output job_t       push_job_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       take;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign take         = in_valid_i && push_ready_i;

  always_comb begin
    push_job_o          = '0;
    push_job_o.msg_last = last_byte_i;
    unique case (phase_q)
      PH_1: begin
        push_job_o.chars[0] = b64_char({left_q[1:0], data_byte_i[7:4]});
        left_d  = data_byte_i[3:0];
        phase_d = PH_2;
        if (last_byte_i) begin
          push_job_o.chars[1] = b64_char({data_byte_i[3:0], 2'b00});
          push_job_o.chars[2] = PadChar;
          push_job_o.last_idx = 2'd2;
        end
      end
      PH_2: begin
        push_job_o.chars[0] = b64_char({left_q, data_byte_i[7:6]});
        push_job_o.chars[1] = b64_char(data_byte_i[5:0]);
        push_job_o.last_idx = 2'd1;
        left_d  = 4'd0;
        phase_d = PH_0;
      end
      default: begin
        push_job_o.chars[0] = b64_char(data_byte_i[7:2]);
        left_d  = {2'b00, data_byte_i[1:0]};
        phase_d = PH_1;
        if (last_byte_i) begin
          push_job_o.chars[1] = b64_char({data_byte_i[1:0], 4'b0000});
          push_job_o.chars[2] = PadChar;
          push_job_o.chars[3] = PadChar;
          push_job_o.last_idx = 2'd3;
        end
      end
    endcase
    // end of message: next byte opens a fresh group
    if (last_byte_i) begin
      left_d  = 4'd0;
      phase_d = PH_0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      left_q  <= 4'd0;
    end else if (take) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

/* design/b64e_queue.sv */
// Short register queue of character jobs between front and back end.
// Uses b64e_pkg for the job type.
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int unsigned Depth = QDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count exceeds depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(Depth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

/* design/b64e_back.sv */
// Back end: walks the characters of each queued job, one per cycle while the
// output is not stalled, into the output register. Uses b64e_pkg for the job type.
module b64e_back
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  job_t       pop_job_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  job_t       job_q;
  logic [1:0] idx_q;
  logic       busy_q;
  logic       out_valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       load, emit, emit_final;

  assign load        = !out_valid_q || out_ready_i;
  assign emit        = busy_q && load;
  assign emit_final  = emit && (idx_q == job_q.last_idx);
  assign pop_ready_o = !busy_q || emit_final;

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      job_q <= pop_job_i;
    end
    if (emit) begin
      char_q <= job_q.chars[idx_q];
      last_q <= job_q.msg_last && (idx_q == job_q.last_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_ready_o) begin
        busy_q <= pop_valid_i;
        idx_q  <= 2'd0;
      end else if (emit) begin
        idx_q <= idx_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= emit;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= job_q.last_idx))
    else $error("character index beyond end of job");
  a_job_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !emit_final) |=> (busy_q && idx_q == $past(idx_q) + 2'd1))
    else $error("job dropped before all characters were sent");
`endif

endmodule
